/* sv/gsa_pkg.sv */
package gsa_pkg;

    // table geometry
    localparam int CAPACITY = 256;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // free search tree: groups of sixteen slots
    localparam int GRP_W  = 4;
    localparam int GRP    = 1 << GRP_W;
    localparam int NGRP   = (CAPACITY + GRP - 1) / GRP;
    localparam int GIDX_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int FIND_W = GIDX_W + GRP_W;

    // field widths
    localparam int MODE_W   = 2;
    localparam int SIDX_W   = 16;
    localparam int GEN_W    = 16;
    localparam int STATUS_W = 2;
    localparam int GOUT_W   = 8;
    localparam int LIVE_W   = 9;

    // generation of a slot that was never written since reset
    localparam logic [GEN_W-1:0] GEN_RESET = GEN_W'(1);

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    // command from the sequencer to the generation store
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [GEN_W-1:0] wr_gen;
        logic             bump_all;
    } gen_cmd_t;

endpackage

/* sv/gsa_free_finder.sv */
module gsa_free_finder (
    input  logic                          aclk,
    input  logic [gsa_pkg::CAPACITY-1:0]  alive,
    output logic                          found,
    output logic [gsa_pkg::IDX_W-1:0]     free_index
);
    import gsa_pkg::*;

    logic [NGRP*GRP-1:0] padded;
    logic [NGRP-1:0]     grp_any_next;
    logic [GRP_W-1:0]    grp_first_next [NGRP];
    logic [NGRP-1:0]     grp_any_reg;
    logic [GRP_W-1:0]    grp_first_reg [NGRP];
    logic [GIDX_W-1:0]   sel;
    logic [FIND_W-1:0]   full_idx;

    // pad past the end of the table with busy slots
    always_comb begin
        padded = '1;
        padded[CAPACITY-1:0] = alive;
    end

    // first level: lowest free slot inside each group
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_any_next[g]   = 1'b0;
            grp_first_next[g] = '0;
            for (int b = GRP - 1; b >= 0; b--) begin
                if (!padded[g*GRP + b]) begin
                    grp_any_next[g]   = 1'b1;
                    grp_first_next[g] = GRP_W'(b);
                end
            end
        end
    end

    // group summary register
    always_ff @(posedge aclk) begin
        grp_any_reg   <= grp_any_next;
        grp_first_reg <= grp_first_next;
    end

    // second level: lowest group with a free slot
    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_any_reg[g]) begin
                found = 1'b1;
                sel   = GIDX_W'(g);
            end
        end
        full_idx   = {sel, grp_first_reg[sel]};
        free_index = full_idx[IDX_W-1:0];
    end

endmodule

/* sv/gsa_gen_store.sv */
module gsa_gen_store (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  gsa_pkg::gen_cmd_t         cmd,
    output logic [gsa_pkg::GEN_W-1:0] rd_gen
);
    import gsa_pkg::*;

    // stored value is the generation minus the clear epoch
    logic [GEN_W-1:0]    mem [CAPACITY];
    logic [CAPACITY-1:0] valid_reg;
    logic [GEN_W-1:0]    epoch_reg;
    logic [GEN_W-1:0]    mem_q_reg;
    logic                valid_q_reg;

    // generation memory, one read and one write port
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr] <= cmd.wr_gen - epoch_reg;
        end
        if (cmd.rd_en) begin
            mem_q_reg <= mem[cmd.rd_addr];
        end
    end

    // written marks and clear epoch
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            epoch_reg   <= '0;
            valid_q_reg <= 1'b0;
        end else begin
            if (cmd.wr_en) begin
                valid_reg[cmd.wr_addr] <= 1'b1;
            end
            if (cmd.bump_all) begin
                epoch_reg <= epoch_reg + GEN_W'(1);
            end
            if (cmd.rd_en) begin
                valid_q_reg <= valid_reg[cmd.rd_addr];
            end
        end
    end

    // unwritten slots read as the reset generation plus the clear epoch
    assign rd_gen = (valid_q_reg ? mem_q_reg : GEN_RESET) + epoch_reg;

endmodule

/* sv/generational_slot_allocator_top.sv */
// channel  | dir | tdata fields (low bit up)                   | tuser
// s_       | in  | slot_index, handle_generation               | mode
// m_       | out | granted_index, granted_generation, live_total | status
//
// each word passes through three steps in turn: accept, search and generation read, execute
// the free-slot search is a two-level registered tree over the alive bitmap
// reset clears the alive bitmap and the generation written marks at once
// a held result word stalls the execute step; s_tready is low until it moves
module generational_slot_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // slot_index[15:0], handle_generation[31:16]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // granted_index[7:0], granted_generation[23:8],
                                   // live_total[32:24], zero[39:33]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import gsa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_EXEC
    } state_t;

    state_t              state_reg;
    mode_t               mode_reg;
    logic [SIDX_W-1:0]   idx_reg;
    logic [GEN_W-1:0]    hgen_reg;
    logic [IDX_W-1:0]    addr_reg;
    logic                found_reg;
    logic [CAPACITY-1:0] alive_reg;
    logic [LIVE_W-1:0]   live_reg;

    logic                m_tvalid_reg;
    status_t             status_reg;
    logic [GOUT_W-1:0]   gidx_reg;
    logic [GEN_W-1:0]    ggen_reg;
    logic [LIVE_W-1:0]   live_out_reg;

    status_t             status_next;
    logic [GOUT_W-1:0]   gidx_next;
    logic [GEN_W-1:0]    ggen_next;
    logic [LIVE_W-1:0]   live_next;

    logic                found;
    logic [IDX_W-1:0]    free_index;
    logic [IDX_W-1:0]    rd_addr;
    logic [GEN_W-1:0]    rd_gen;
    gen_cmd_t            cmd;
    logic                out_free;
    logic                exec_go;
    logic                in_range;
    logic                handle_ok;
    logic [SIDX_W-1:0]   addr_wide;

    gsa_free_finder u_finder (
        .aclk       (aclk),
        .alive      (alive_reg),
        .found      (found),
        .free_index (free_index)
    );

    gsa_gen_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rd_gen  (rd_gen)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign exec_go  = (state_reg == S_EXEC) && out_free;

    // read address: searched slot for allocate, handle slot otherwise
    assign rd_addr = (mode_reg == MODE_ALLOC) ? free_index : idx_reg[IDX_W-1:0];

    // handle check against the slot just read
    assign in_range  = (32'(idx_reg) < CAPACITY);
    assign handle_ok = (hgen_reg != '0) && in_range && alive_reg[addr_reg]
                       && (rd_gen == hgen_reg);
    assign addr_wide = SIDX_W'(addr_reg);

    // generation store commands
    always_comb begin
        cmd          = '0;
        cmd.rd_en    = (state_reg == S_FIND);
        cmd.rd_addr  = rd_addr;
        cmd.wr_addr  = addr_reg;
        cmd.wr_gen   = rd_gen + GEN_W'(1);
        cmd.wr_en    = exec_go && (mode_reg == MODE_FREE) && handle_ok;
        cmd.bump_all = exec_go && (mode_reg == MODE_CLEAR);
    end

    // result fields and live count for the word in execute
    always_comb begin
        status_next = ST_OK;
        gidx_next   = '0;
        ggen_next   = '0;
        live_next   = live_reg;
        unique case (mode_reg)
            MODE_ALLOC: begin
                if (found_reg) begin
                    live_next = live_reg + LIVE_W'(1);
                    gidx_next = addr_wide[GOUT_W-1:0];
                    ggen_next = rd_gen;
                end else begin
                    status_next = ST_FULL;
                end
            end
            MODE_FREE: begin
                if (handle_ok) begin
                    if (live_reg != '0) begin
                        live_next = live_reg - LIVE_W'(1);
                    end
                end else begin
                    status_next = ST_BAD;
                end
            end
            MODE_LOOKUP: begin
                if (!handle_ok) begin
                    status_next = ST_BAD;
                end
            end
            MODE_CLEAR: begin
                live_next = '0;
            end
        endcase
    end

    // sequencer, slot state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            alive_reg    <= '0;
            live_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready && !exec_go) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        mode_reg  <= mode_t'(s_tuser);
                        idx_reg   <= s_tdata[15:0];
                        hgen_reg  <= s_tdata[31:16];
                        state_reg <= S_FIND;
                    end
                end
                S_FIND: begin
                    addr_reg  <= rd_addr;
                    found_reg <= found;
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        status_reg   <= status_next;
                        gidx_reg     <= gidx_next;
                        ggen_reg     <= ggen_next;
                        live_reg     <= live_next;
                        live_out_reg <= live_next;
                        state_reg    <= S_IDLE;
                        unique case (mode_reg)
                            MODE_ALLOC: begin
                                if (found_reg) begin
                                    alive_reg[addr_reg] <= 1'b1;
                                end
                            end
                            MODE_FREE: begin
                                if (handle_ok) begin
                                    alive_reg[addr_reg] <= 1'b0;
                                end
                            end
                            MODE_LOOKUP: begin
                            end
                            MODE_CLEAR: begin
                                alive_reg <= '0;
                            end
                        endcase
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result word
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'b0, live_out_reg, ggen_reg, gidx_reg};

endmodule
